FILE: src/mptw_pkg.sv
// shared constants, types and address helper for the page table walker
package mptw_pkg;

  localparam int unsigned LEVELS      = 2;
  localparam int unsigned PAGE_SHIFT  = 12;
  localparam int unsigned INDEX_BITS  = 9;
  localparam int unsigned ENTRY_SHIFT = 3;

  localparam int unsigned VA_W     = 48;
  localparam int unsigned ADDR_W   = 64;
  localparam int unsigned RIGHTS_W = 4;
  localparam int unsigned LVL_W    = 3;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned SHIFT_W  = 7;

  localparam int unsigned RIGHT_INTERN_BIT = 3;

  typedef enum logic [KIND_W-1:0] {
    KIND_READ   = 2'd0,
    KIND_DONE   = 2'd1,
    KIND_FAULT  = 2'd2,
    KIND_REJECT = 2'd3
  } kind_e;

  typedef enum logic {
    REQ_START = 1'b0,
    REQ_PTE   = 1'b1
  } req_e;

  typedef struct packed {
    logic                req_type;
    logic [VA_W-1:0]     virt_addr;
    logic [RIGHTS_W-1:0] access_rights;
    logic [ADDR_W-1:0]   pte_word;
  } item_t;

  typedef struct packed {
    logic                busy;
    logic [LVL_W-1:0]    level;
    logic [VA_W-1:0]     virt;
    logic [RIGHTS_W-1:0] rights;
  } walk_state_t;

  typedef struct packed {
    kind_e               kind;
    logic [ADDR_W-1:0]   mem_addr;
    logic [LVL_W-1:0]    level;
    logic [ADDR_W-1:0]   phys_addr;
    logic [ADDR_W-1:0]   page_base;
    logic [RIGHTS_W-1:0] flags;
  } result_t;

  // table base plus index field of the given level scaled to entry size
  function automatic logic [ADDR_W-1:0] entry_addr(logic [ADDR_W-1:0] table_base,
                                                    logic [VA_W-1:0]   virt,
                                                    logic [LVL_W-1:0]  level);
    logic [SHIFT_W-1:0]    sh;
    logic [ADDR_W-1:0]     v64;
    logic [INDEX_BITS-1:0] idx;
    sh  = SHIFT_W'(PAGE_SHIFT) + SHIFT_W'(level) * SHIFT_W'(INDEX_BITS);
    v64 = ADDR_W'(virt);
    idx = INDEX_BITS'(v64 >> sh);
    return table_base + (ADDR_W'(idx) << ENTRY_SHIFT);
  endfunction

endpackage

FILE: src/mptw_step.sv
// one walk step: checks an item against the walk state, gives result and next state
module mptw_step (
  input  mptw_pkg::item_t       item_i,
  input  mptw_pkg::walk_state_t state_i,
  input  logic [63:0]           root_addr_i,
  output mptw_pkg::walk_state_t state_o,
  output mptw_pkg::result_t     result_o
);
  import mptw_pkg::*;

  logic [RIGHTS_W-1:0] flags;
  logic [RIGHTS_W-1:0] need;
  logic [ADDR_W-1:0]   base;
  logic [ADDR_W-1:0]   offset;
  logic [LVL_W-1:0]    next_level;
  logic                last;

  always_comb begin
    flags      = item_i.pte_word[RIGHTS_W-1:0];
    base       = {item_i.pte_word[ADDR_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
    offset     = ADDR_W'(state_i.virt[PAGE_SHIFT-1:0]);
    last       = (state_i.level == '0);
    next_level = state_i.level - LVL_W'(1);
    need       = state_i.rights;
    if (!last) begin
      need[RIGHT_INTERN_BIT] = 1'b0;
    end
  end

  always_comb begin
    state_o  = state_i;
    result_o = '{kind: KIND_REJECT, default: '0};
    if (item_i.req_type == REQ_START) begin
      if (!state_i.busy) begin
        state_o.busy   = 1'b1;
        state_o.level  = LVL_W'(LEVELS - 1);
        state_o.virt   = item_i.virt_addr;
        state_o.rights = item_i.access_rights;
        result_o.kind  = KIND_READ;
        result_o.level = LVL_W'(LEVELS - 1);
        result_o.mem_addr = entry_addr(root_addr_i, item_i.virt_addr, LVL_W'(LEVELS - 1));
      end
    end else if (state_i.busy) begin
      if ((flags & need) != need) begin
        state_o.busy   = 1'b0;
        result_o.kind  = KIND_FAULT;
        result_o.level = state_i.level;
      end else if (!last) begin
        state_o.level     = next_level;
        result_o.kind     = KIND_READ;
        result_o.level    = next_level;
        result_o.mem_addr = entry_addr(base, state_i.virt, next_level);
      end else begin
        state_o.busy       = 1'b0;
        result_o.kind      = KIND_DONE;
        result_o.phys_addr = base + offset;
        result_o.page_base = base;
        result_o.flags     = flags;
      end
    end
  end

endmodule

FILE: src/multilevel_page_table_walker.sv
// radix page table walker top level: input register, step logic, result register
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+----------------------------------------
//   in      | in        | in_valid_i / in_stall_o | req_type, virt_addr, access_rights, pte
//   out     | out       | out_valid_o/ out_stall_i| kind, mem_addr, level, phys, base, flags
//   cfg     | in        | cfg_we_i                | cfg_wdata_i (root table address)
//
// one item per cycle unless a result is held; items pass the input, then the result register
// the walk state is read and updated as an item moves from the input register into
// the result register, so items are handled strictly in order
// reset clears walk state, root address and both valid flags
// a held result stalls the input register; in_stall_o rises only when both are full
module multilevel_page_table_walker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [63:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        req_type_i,
  input  logic [47:0] virt_addr_i,
  input  logic [3:0]  access_rights_i,
  input  logic [63:0] pte_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  result_kind_o,
  output logic [63:0] mem_addr_o,
  output logic [2:0]  walk_level_o,
  output logic [63:0] phys_addr_o,
  output logic [63:0] page_base_o,
  output logic [3:0]  page_flags_o
);
  import mptw_pkg::*;

  // input stage
  logic  in_vld_q;
  logic  in_vld_d;
  item_t item_q;

  // result stage
  logic    out_vld_q;
  logic    out_vld_d;
  result_t res_q;
  result_t res_d;

  // walk state and root register
  walk_state_t st_q;
  walk_state_t st_d;
  walk_state_t st_next;
  logic [ADDR_W-1:0] root_q;

  logic advance;
  logic in_xfer;

  // item moves on when the result register is empty or being drained
  assign advance    = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !advance;
  assign in_xfer    = in_valid_i && !in_stall_o;

  mptw_step u_step (
    .item_i      (item_q),
    .state_i     (st_q),
    .root_addr_i (root_q),
    .state_o     (st_next),
    .result_o    (res_d)
  );

  always_comb begin
    in_vld_d  = in_xfer || (in_vld_q && !advance);
    st_d      = advance ? st_next : st_q;
    out_vld_d = advance || (out_vld_q && out_stall_i);
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      st_q      <= '0;
      root_q    <= '0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      st_q      <= st_d;
      if (cfg_we_i) begin
        root_q <= cfg_wdata_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q.req_type      <= req_type_i;
      item_q.virt_addr     <= virt_addr_i;
      item_q.access_rights <= access_rights_i;
      item_q.pte_word      <= pte_word_i;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign result_kind_o = res_q.kind;
  assign mem_addr_o    = res_q.mem_addr;
  assign walk_level_o  = res_q.level;
  assign phys_addr_o   = res_q.phys_addr;
  assign page_base_o   = res_q.page_base;
  assign page_flags_o  = res_q.flags;

endmodule

FILE: dv/mptw_walk_checker.sv
// page walk checker: predicts walker results from observed transfers and compares them
module mptw_walk_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [63:0] cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic        req_type_i,
  input  logic [47:0] virt_addr_i,
  input  logic [3:0]  access_rights_i,
  input  logic [63:0] pte_word_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [1:0]  result_kind_i,
  input  logic [63:0] mem_addr_i,
  input  logic [2:0]  walk_level_i,
  input  logic [63:0] phys_addr_i,
  input  logic [63:0] page_base_i,
  input  logic [3:0]  page_flags_i,
  output int          mismatch_count_o,
  output int          outstanding_o,
  output int          done_count_o,
  output int          fault_count_o
);
  import mptw_pkg::*;

  localparam logic [ADDR_W-1:0] PageOffsetMask = (64'd1 << PAGE_SHIFT) - 64'd1;

  // shadow walk state
  logic [ADDR_W-1:0]   root_addr;
  logic                walk_busy;
  logic [LVL_W-1:0]    level_left;
  logic [VA_W-1:0]     saved_virt;
  logic [RIGHTS_W-1:0] saved_rights;

  result_t walk_results_q[$];

  initial begin
    mismatch_count_o = 0;
    outstanding_o    = 0;
    done_count_o     = 0;
    fault_count_o    = 0;
  end

  function automatic logic [ADDR_W-1:0] pte_address(logic [ADDR_W-1:0] table_base,
                                                    logic [VA_W-1:0]   va,
                                                    logic [LVL_W-1:0]  lvl);
    int unsigned       sh;
    logic [ADDR_W-1:0] index;
    sh    = PAGE_SHIFT + int'(lvl) * INDEX_BITS;
    index = '0;
    if (sh < 64) begin
      index = (64'(va) >> sh) & ((64'd1 << INDEX_BITS) - 64'd1);
    end
    return table_base + (index << ENTRY_SHIFT);
  endfunction

  // one walker step on the shadow state
  task automatic walk_step(input logic req, input logic [VA_W-1:0] va,
                           input logic [RIGHTS_W-1:0] rights, input logic [ADDR_W-1:0] pte,
                           output result_t res);
    logic [RIGHTS_W-1:0] flags;
    logic [RIGHTS_W-1:0] need;
    logic [ADDR_W-1:0]   base;
    res      = '0;
    res.kind = KIND_REJECT;
    flags    = pte[RIGHTS_W-1:0];
    base     = pte & ~PageOffsetMask;
    if (req == REQ_START) begin
      if (!walk_busy) begin
        walk_busy    = 1'b1;
        level_left   = LVL_W'(LEVELS - 1);
        saved_virt   = va;
        saved_rights = rights;
        res.kind     = KIND_READ;
        res.mem_addr = pte_address(root_addr, saved_virt, level_left);
        res.level    = level_left;
      end
    end else if (walk_busy) begin
      need = saved_rights;
      // upper levels do not care about the intern right
      if (level_left != 0) need[RIGHT_INTERN_BIT] = 1'b0;
      if ((flags & need) != need) begin
        res.kind  = KIND_FAULT;
        res.level = level_left;
        walk_busy = 1'b0;
      end else if (level_left != 0) begin
        level_left   = level_left - 1'b1;
        res.kind     = KIND_READ;
        res.mem_addr = pte_address(base, saved_virt, level_left);
        res.level    = level_left;
      end else begin
        res.kind      = KIND_DONE;
        res.phys_addr = base + (64'(saved_virt) & PageOffsetMask);
        res.page_base = base;
        res.flags     = flags;
        walk_busy     = 1'b0;
      end
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] exp_val,
                             input logic [63:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s: expected %h, got %h", name, exp_val, act_val);
      mismatch_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t res;
    result_t oldest;
    if (!rst_ni) begin
      root_addr    = '0;
      walk_busy    = 1'b0;
      level_left   = '0;
      saved_virt   = '0;
      saved_rights = '0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (walk_results_q.size() == 0) begin
          $error("result with no pending expectation: kind %0d", result_kind_i);
          mismatch_count_o++;
        end else begin
          oldest = walk_results_q[0];
          walk_results_q.delete(0);
          check_field("result_kind", 64'(oldest.kind), 64'(result_kind_i));
          check_field("mem_addr", oldest.mem_addr, mem_addr_i);
          check_field("walk_level", 64'(oldest.level), 64'(walk_level_i));
          check_field("phys_addr", oldest.phys_addr, phys_addr_i);
          check_field("page_base", oldest.page_base, page_base_i);
          check_field("page_flags", 64'(oldest.flags), 64'(page_flags_i));
        end
      end
      if (cfg_we_i) root_addr = cfg_wdata_i;
      if (in_valid_i && !in_stall_i) begin
        walk_step(req_type_i, virt_addr_i, access_rights_i, pte_word_i, res);
        if (res.kind == KIND_DONE)  done_count_o++;
        if (res.kind == KIND_FAULT) fault_count_o++;
        walk_results_q.insert(walk_results_q.size(), res);
      end
      outstanding_o = walk_results_q.size();
    end
  end

endmodule

FILE: dv/multilevel_page_table_walker_tb.sv
// testbench top for the page table walker: stimulus, idling, verdict
module multilevel_page_table_walker_tb;
  import mptw_pkg::*;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        cfg_we_i        = 1'b0;
  logic [63:0] cfg_wdata_i     = '0;
  logic        in_valid_i      = 1'b0;
  logic        in_stall_o;
  logic        req_type_i      = 1'b0;
  logic [47:0] virt_addr_i     = '0;
  logic [3:0]  access_rights_i = '0;
  logic [63:0] pte_word_i      = '0;
  logic        out_valid_o;
  logic        out_stall_i     = 1'b0;
  logic [1:0]  result_kind_o;
  logic [63:0] mem_addr_o;
  logic [2:0]  walk_level_o;
  logic [63:0] phys_addr_o;
  logic [63:0] page_base_o;
  logic [3:0]  page_flags_o;

  int mismatch_count;
  int outstanding;
  int done_count;
  int fault_count;

  // chance per cycle, in percent, that the sender idles or the receiver stalls
  int idle_pct  = 0;
  int stall_pct = 0;
  int items_sent = 0;
  int root_writes = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  multilevel_page_table_walker i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .req_type_i      (req_type_i),
    .virt_addr_i     (virt_addr_i),
    .access_rights_i (access_rights_i),
    .pte_word_i      (pte_word_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .result_kind_o   (result_kind_o),
    .mem_addr_o      (mem_addr_o),
    .walk_level_o    (walk_level_o),
    .phys_addr_o     (phys_addr_o),
    .page_base_o     (page_base_o),
    .page_flags_o    (page_flags_o)
  );

  mptw_walk_checker i_walk_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .req_type_i       (req_type_i),
    .virt_addr_i      (virt_addr_i),
    .access_rights_i  (access_rights_i),
    .pte_word_i       (pte_word_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .result_kind_i    (result_kind_o),
    .mem_addr_i       (mem_addr_o),
    .walk_level_i     (walk_level_o),
    .phys_addr_i      (phys_addr_o),
    .page_base_i      (page_base_o),
    .page_flags_i     (page_flags_o),
    .mismatch_count_o (mismatch_count),
    .outstanding_o    (outstanding),
    .done_count_o     (done_count),
    .fault_count_o    (fault_count)
  );

  // receiver back-pressure, redrawn every cycle at the falling edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // one input transfer; called and returning at a falling edge
  task automatic send_item(input req_e req, input logic [47:0] va,
                           input logic [3:0] rights, input logic [63:0] pte);
    // random idle cycles ahead of the item
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    req_type_i      <= req;
    virt_addr_i     <= va;
    access_rights_i <= rights;
    pte_word_i      <= pte;
    // payload holds until the walker takes it
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
    items_sent++;
  endtask

  // root table writes only happen once every pending result has come back
  task automatic write_root(input logic [63:0] value);
    in_valid_i <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    root_writes++;
  endtask

  // a well-formed walk: start plus one entry per level, rights mostly granted
  task automatic run_walk();
    logic [47:0] va;
    logic [3:0]  rights;
    logic [63:0] pte;
    va     = 48'({$urandom, $urandom});
    rights = 4'($urandom_range(15));
    send_item(REQ_START, va, rights, {$urandom, $urandom});
    for (int lvl = 0; lvl < LEVELS; lvl++) begin
      pte = {$urandom, $urandom};
      if ($urandom_range(99) < 88) begin
        pte[3:0] = rights | 4'($urandom_range(15));
      end else begin
        pte[3:0] = 4'($urandom_range(15));
      end
      // start-only fields carry noise on entry transfers
      send_item(REQ_PTE, 48'({$urandom, $urandom}), 4'($urandom_range(15)), pte);
    end
  endtask

  initial begin
    int          phase_idle[4];
    int          phase_stall[4];
    logic [63:0] phase_root[4];
    int          phase_start;

    phase_idle  = '{0, 52, 0, 20};
    phase_stall = '{0, 0, 52, 20};
    phase_root  = '{64'd0, {$urandom, $urandom}, 64'hFFFF_FFFF_FFFF_F000,
                    {$urandom, $urandom}};

    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed part, root at the top of the address space so entry addresses wrap
    write_root(64'hFFFF_FFFF_FFFF_FFFF);
    // entry while idle is rejected
    send_item(REQ_PTE, 48'h0, 4'h0, 64'h0000_0000_0000_1007);
    send_item(REQ_START, 48'h0, 4'h0, 64'h0);
    // start while busy is rejected, walk goes on
    send_item(REQ_START, 48'hFFFF_FFFF_FFFF, 4'hF, 64'h0);
    send_item(REQ_PTE, 48'h0, 4'h0, 64'hFFFF_FFFF_FFFF_F000);
    send_item(REQ_PTE, 48'h0, 4'h0, 64'h0);
    // all rights requested: intern ignored above the last level, needed at it
    send_item(REQ_START, 48'hFFFF_FFFF_FFFF, 4'hF, 64'h0);
    send_item(REQ_PTE, 48'h0, 4'h0, 64'hFFFF_FFFF_FFFF_FFF7);
    send_item(REQ_PTE, 48'h0, 4'h0, 64'h8000_0000_0000_0007);
    // fault at the top level, then an entry after the walk ended
    send_item(REQ_START, 48'h1234_5678_9ABC, 4'h3, 64'h0);
    send_item(REQ_PTE, 48'h0, 4'h0, 64'h0000_0000_0000_0001);
    send_item(REQ_PTE, 48'h0, 4'h0, 64'hFFFF_FFFF_FFFF_FFFF);
    // all-ones entries complete the walk with the highest page base
    send_item(REQ_START, 48'h8000_0000_0000, 4'h5, 64'h0);
    send_item(REQ_PTE, 48'h0, 4'h0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(REQ_PTE, 48'h0, 4'h0, 64'hFFFF_FFFF_FFFF_FFFF);
    // intern-only request
    send_item(REQ_START, 48'h0000_0000_0FFF, 4'h8, 64'h0);
    send_item(REQ_PTE, 48'h0, 4'h0, 64'h0000_0000_0000_0000);
    send_item(REQ_PTE, 48'h0, 4'h0, 64'h5555_5555_5555_5558);
    // write missing at the last level
    send_item(REQ_START, 48'h7FFF_FFFF_FFFF, 4'h2, 64'h0);
    send_item(REQ_PTE, 48'h0, 4'h0, 64'hAAAA_AAAA_AAAA_A002);
    send_item(REQ_PTE, 48'h0, 4'h0, 64'hAAAA_AAAA_AAAA_A00D);

    // random phases, each with its own root and idling mix
    for (int p = 0; p < 4; p++) begin
      write_root(phase_root[p]);
      idle_pct    = phase_idle[p];
      stall_pct   = phase_stall[p];
      phase_start = items_sent;
      while (items_sent - phase_start < 140) begin
        if ($urandom_range(99) < 85) begin
          run_walk();
        end else begin
          // noise: stray starts and entries in any walk state
          send_item(req_e'($urandom_range(1)), 48'({$urandom, $urandom}),
                    4'($urandom_range(15)), {$urandom, $urandom});
        end
      end
    end

    in_valid_i <= 1'b0;
    stall_pct = 0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);

    $display("walker run: %0d input transfers, %0d root table writes", items_sent,
             root_writes);
    $display("walks completed %0d, permission faults %0d, field mismatches %0d",
             done_count, fault_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #400000;
    $display("FAIL");
    $finish;
  end

endmodule

FILE: multilevel_page_table_walker.f
src/mptw_pkg.sv
src/mptw_step.sv
src/multilevel_page_table_walker.sv
dv/mptw_walk_checker.sv
dv/multilevel_page_table_walker_tb.sv
